// ===== design/rnn_pkg.sv =====
package rnn_pkg;

	localparam int MAX_NEURONS   = 32;
	localparam int MAX_GROUPS    = 2;
	localparam int TABLE_ENTRIES = 1024;

	localparam int IW   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
	localparam int CW   = $clog2(MAX_NEURONS + 1);
	localparam int GIW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW  = $clog2(MAX_GROUPS + 1);
	localparam int WT_DEPTH = MAX_GROUPS * MAX_NEURONS * MAX_NEURONS;
	localparam int WAW  = $clog2(WT_DEPTH);
	localparam int TW   = $clog2(TABLE_ENTRIES);
	localparam int ACW  = 32 + $clog2(MAX_GROUPS * MAX_NEURONS) + 2;

	localparam logic [2:0] REG_NEURON_COUNT = 3'd0;
	localparam logic [2:0] REG_GROUP_COUNT  = 3'd1;
	localparam logic [2:0] REG_ALPHA        = 3'd2;
	localparam logic [2:0] REG_BETA         = 3'd3;
	localparam logic [2:0] REG_INV_TAU      = 3'd4;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_RD_RI    = 13'b0000000000100,
		ST_MAC      = 13'b0000000001000,
		ST_DRAIN    = 13'b0000000010000,
		ST_ACT      = 13'b0000000100000,
		ST_MULU     = 13'b0000001000000,
		ST_TRD      = 13'b0000010000000,
		ST_MULG     = 13'b0000100000000,
		ST_UPD      = 13'b0001000000000,
		ST_EMIT_RD  = 13'b0010000000000,
		ST_EMIT_OUT = 13'b0100000000000,
		ST_SPARE    = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic [5:0]         neuron_count;
		logic [1:0]         group_count;
		logic signed [20:0] alpha;
		logic [15:0]        beta;
		logic [15:0]        inv_tau;
	} cfg_t;

	typedef struct packed {
		logic           wt_we;
		logic           wt_zero;
		logic [WAW-1:0] wt_waddr;
		logic [WAW-1:0] wt_raddr;
		logic           rt_we;
		logic           rt_zero;
		logic [IW-1:0]  rt_waddr;
		logic [IW-1:0]  rt_raddr;
		logic           mac_issue;
		logic           ri_rd;
		logic           acc_clr;
		logic           gain_ld;
		logic           act_en;
		logic           mulu_en;
		logic           trd_en;
		logic           mulg_en;
		logic           upd_en;
		logic           buf_rd;
		logic [IW-1:0]  buf_addr;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} sts_t;

	typedef logic [15:0] sig_table_t [TABLE_ENTRIES];

	// restoring division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], a[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] sig_entry(input int k);
		logic [63:0] twok, span, f, term, pos, neg, y, num, den, s, e;
		logic        nonneg;
		e      = 64'(TABLE_ENTRIES);
		twok   = 64'(2 * k);
		nonneg = twok >= e;
		span   = nonneg ? twok - e : e - twok;
		f      = udiv64(span << 31, e);
		term   = 64'd1 << 31;
		pos    = term;
		neg    = '0;
		for (int n = 1; n <= 14; n++) begin
			term = udiv64((term * f) >> 31, 64'(n));
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		y = (pos >= neg) ? pos - neg : 64'd0;
		for (int n = 0; n < 4; n++)
			y = (y * y + (64'd1 << 30)) >> 31;
		den = (64'd1 << 31) + y;
		num = (nonneg ? (64'd1 << 31) : y) << 16;
		s   = udiv64(num + (den >> 1), den);
		if (s > 64'd65535) s = 64'd65535;
		return s[15:0];
	endfunction

	function automatic sig_table_t build_sig_table();
		sig_table_t t;
		for (int k = 0; k < TABLE_ENTRIES; k++)
			t[k] = sig_entry(k);
		return t;
	endfunction

endpackage

// ===== design/rnn_cfg.sv =====
module rnn_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic [2:0]    cfg_index,
	input  logic [20:0]   cfg_data,
	output rnn_pkg::cfg_t cfg
);
	import rnn_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neuron_count <= 6'd32;
			cfg_q.group_count  <= 2'd1;
			cfg_q.alpha        <= '0;
			cfg_q.beta         <= 16'd4096;
			cfg_q.inv_tau      <= 16'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NEURON_COUNT: cfg_q.neuron_count <= cfg_data[5:0];
				REG_GROUP_COUNT:  cfg_q.group_count  <= cfg_data[1:0];
				REG_ALPHA:        cfg_q.alpha        <= $signed(cfg_data);
				REG_BETA:         cfg_q.beta         <= cfg_data[15:0];
				REG_INV_TAU:      cfg_q.inv_tau      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== design/rnn_ctrl.sv =====
module rnn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  rnn_pkg::cfg_t cfg,
	input  logic          in_valid,
	input  logic          action,
	input  logic          group,
	input  logic [4:0]    row,
	input  logic [4:0]    col,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [4:0]    neuron,
	output logic          last,
	output rnn_pkg::cmd_t cmd,
	input  rnn_pkg::sts_t sts
);
	import rnn_pkg::*;

	state_t         state_q, state_d;
	logic [WAW:0]   clr_q;
	logic [IW-1:0]  i_q, j_q;
	logic [GIW-1:0] g_q;
	logic [CW-1:0]  n_q;
	logic [GCW-1:0] ng_q;
	logic [CW-1:0]  n_sat;
	logic [GCW-1:0] ng_sat;
	logic           i_last, j_last, g_last;

	always_comb begin
		n_sat  = (int'(cfg.neuron_count) > MAX_NEURONS) ? CW'(MAX_NEURONS)
		                                                : CW'(cfg.neuron_count);
		ng_sat = (int'(cfg.group_count) > MAX_GROUPS) ? GCW'(MAX_GROUPS)
		                                              : GCW'(cfg.group_count);
	end

	assign i_last = i_q == IW'(n_q - 1'b1);
	assign j_last = j_q == IW'(n_q - 1'b1);
	assign g_last = g_q == GIW'(ng_q - 1'b1);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wt_we    = 1'b1;
				cmd.wt_zero  = 1'b1;
				cmd.wt_waddr = clr_q[WAW-1:0];
				if (int'(clr_q) < MAX_NEURONS) begin
					cmd.rt_we    = 1'b1;
					cmd.rt_zero  = 1'b1;
					cmd.rt_waddr = clr_q[IW-1:0];
				end
				if (int'(clr_q) == WT_DEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.wt_waddr = WAW'((int'(group) * MAX_NEURONS + int'(row)) * MAX_NEURONS
				                    + int'(col));
				if (in_valid && action == ACT_WRITE) begin
					cmd.wt_we = (int'(group) < MAX_GROUPS) && (int'(row) < MAX_NEURONS)
					            && (int'(col) < MAX_NEURONS);
				end else if (in_valid) begin
					cmd.gain_ld = 1'b1;
					if (n_sat != '0) state_d = ST_RD_RI;
				end
			end
			ST_RD_RI: begin
				cmd.rt_raddr = i_q;
				cmd.ri_rd    = 1'b1;
				cmd.acc_clr  = 1'b1;
				state_d      = (ng_q != '0) ? ST_MAC : ST_DRAIN;
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.wt_raddr  = WAW'((int'(g_q) * MAX_NEURONS + int'(i_q)) * MAX_NEURONS
				                     + int'(j_q));
				cmd.rt_raddr  = j_q;
				if (j_last && g_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: if (!sts.busy) state_d = ST_ACT;
			ST_ACT: begin
				cmd.act_en = 1'b1;
				state_d    = ST_MULU;
			end
			ST_MULU: begin
				cmd.mulu_en = 1'b1;
				state_d     = ST_TRD;
			end
			ST_TRD: begin
				cmd.trd_en = 1'b1;
				state_d    = ST_MULG;
			end
			ST_MULG: begin
				cmd.mulg_en = 1'b1;
				state_d     = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_en   = 1'b1;
				cmd.buf_addr = i_q;
				state_d      = i_last ? ST_EMIT_RD : ST_RD_RI;
			end
			ST_EMIT_RD: begin
				cmd.buf_rd   = 1'b1;
				cmd.buf_addr = i_q;
				state_d      = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				out_valid    = 1'b1;
				cmd.rt_waddr = i_q;
				if (out_ready) begin
					cmd.rt_we = 1'b1;
					state_d   = i_last ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			g_q     <= '0;
			n_q     <= '0;
			ng_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE && in_valid && action == ACT_STEP) begin
				n_q  <= n_sat;
				ng_q <= ng_sat;
				i_q  <= '0;
			end
			if (state_q == ST_RD_RI) begin
				j_q <= '0;
				g_q <= '0;
			end
			if (state_q == ST_MAC) begin
				if (j_last) begin
					j_q <= '0;
					g_q <= g_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			// advance the neuron index; wrap to zero for the emit pass
			if (state_q == ST_UPD) i_q <= i_last ? '0 : i_q + 1'b1;
			if (state_q == ST_EMIT_OUT && out_ready) i_q <= i_q + 1'b1;
		end
	end

	assign neuron = 5'(i_q);
	assign last   = i_last;
endmodule

// ===== design/rnn_datapath.sv =====
module rnn_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  rnn_pkg::cfg_t cfg,
	input  rnn_pkg::cmd_t cmd,
	output rnn_pkg::sts_t sts,
	input  logic [15:0]   weight_value,
	input  logic [15:0]   time_step,
	output logic [15:0]   rate
);
	import rnn_pkg::*;

	localparam sig_table_t SIG_TABLE = build_sig_table();

	logic [15:0] wmem [WT_DEPTH];
	logic [15:0] rmem [MAX_NEURONS];
	logic [15:0] bmem [MAX_NEURONS];

	logic [15:0]         wt_rd_q, rt_rd_q, buf_rd_q, ri_q, tbl_q;
	logic                mac_v_s1, mac_v_s2, ri_v_s1;
	logic signed [32:0]  prod_s2;
	logic signed [ACW-1:0] acc_q;
	logic [24:0]         gain_q;
	logic signed [22:0]  x_q;
	logic signed [39:0]  u_q;
	logic                sat_lo_q, sat_hi_q;
	logic signed [42:0]  gprod_q;
	logic [31:0]         gain_raw;
	logic signed [39:0]  u_off;
	logic [15:0]         t_val;
	logic signed [16:0]  diff;
	logic signed [42:0]  rnd;
	logic signed [18:0]  delta;
	logic signed [19:0]  nr;
	logic [15:0]         nr_clamp;

	always_ff @(posedge clk) begin
		if (cmd.wt_we) wmem[cmd.wt_waddr] <= cmd.wt_zero ? 16'd0 : weight_value;
		wt_rd_q <= wmem[cmd.wt_raddr];
		if (cmd.rt_we) rmem[cmd.rt_waddr] <= cmd.rt_zero ? 16'd0 : buf_rd_q;
		rt_rd_q <= rmem[cmd.rt_raddr];
		if (cmd.upd_en) bmem[cmd.buf_addr] <= nr_clamp;
		if (cmd.buf_rd) buf_rd_q <= bmem[cmd.buf_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			mac_v_s2 <= 1'b0;
			ri_v_s1  <= 1'b0;
		end else begin
			mac_v_s1 <= cmd.mac_issue;
			mac_v_s2 <= mac_v_s1;
			ri_v_s1  <= cmd.ri_rd;
		end
	end

	assign sts.busy = mac_v_s1 | mac_v_s2 | ri_v_s1;
	assign gain_raw = 32'(time_step) * 32'(cfg.inv_tau);
	assign u_off    = u_q + 40'sd134217728;

	always_ff @(posedge clk) begin
		if (cmd.gain_ld) gain_q <= (gain_raw > 32'd16777216) ? 25'd16777216 : 25'(gain_raw);
		if (ri_v_s1) ri_q <= rt_rd_q;
		if (mac_v_s1) prod_s2 <= $signed(wt_rd_q) * $signed({1'b0, rt_rd_q});
		if (cmd.acc_clr) acc_q <= '0;
		else if (mac_v_s2) acc_q <= acc_q + ACW'(prod_s2);
		if (cmd.act_en) x_q <= 23'(acc_q >>> 16) - 23'(cfg.alpha);
		if (cmd.mulu_en) u_q <= 40'($signed({1'b0, cfg.beta}) * x_q);
		if (cmd.trd_en) begin
			sat_lo_q <= u_q < -40'sd134217728;
			sat_hi_q <= u_q >= 40'sd134217728;
			tbl_q    <= SIG_TABLE[u_off[27 -: TW]];
		end
		if (cmd.mulg_en) gprod_q <= $signed({1'b0, gain_q}) * diff;
	end

	always_comb begin
		t_val = sat_lo_q ? 16'd0 : (sat_hi_q ? 16'hFFFF : tbl_q);
		diff  = $signed({1'b0, t_val}) - $signed({1'b0, ri_q});
		rnd   = gprod_q + 43'sd8388608;
		delta = 19'(rnd >>> 24);
		nr    = $signed({4'b0, ri_q}) + 20'(delta);
		if (nr < 0) nr_clamp = 16'd0;
		else if (nr > 20'sd65535) nr_clamp = 16'hFFFF;
		else nr_clamp = nr[15:0];
	end

	assign rate = buf_rd_q;
endmodule

// ===== design/rate_neuron_network_step_top.sv =====
// Leaky rate-neuron network update. An input transfer with action 0 stores one
// signed Q4.12 weight at (group, row, col); the block is idle again in the next
// cycle. An input transfer with action 1 integrates one timestep with
// dt = time_step: each neuron's activation is a weight row times the old rates
// over all groups in use, minus alpha, passed through a sigmoid table and blended
// into the old rate by dt*inverse_tau. All new rates then leave in neuron order,
// last set on the final one. One shared multiply-accumulate unit forms all
// products of a step one after another, and output stalls lengthen the step.
// After reset the weight store and rates are swept to zero, during which no
// input is taken; configuration writes are taken at any time but are meant only
// while the block is idle.
module rate_neuron_network_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        group,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic [15:0] weight_value,
	input  logic [15:0] time_step,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  neuron,
	output logic [15:0] rate,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [20:0] cfg_data
);
	import rnn_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// take configuration writes in every cycle
	assign cfg_ready = 1'b1;

	rnn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequence the clear sweep, weight writes, MAC loop, update and emit
	rnn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.action    (action),
		.group     (group),
		.row       (row),
		.col       (col),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.neuron    (neuron),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

	// hold memories, accumulator, transfer table and the rate update math
	rnn_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.weight_value (weight_value),
		.time_step    (time_step),
		.rate         (rate)
	);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid && in_ready)
		else $error("block not idle after final result");

	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action == ACT_WRITE |=> in_ready)
		else $error("weight write did not return to idle");
`endif
endmodule
